// File: rtl/dhcp_pkg.sv
`timescale 1ns / 1ps

package dhcp_pkg;

    localparam int MAX_MSG_BYTES = 1024;
    localparam int OFS_W         = $clog2(MAX_MSG_BYTES + 1);

    localparam int HDR_BYTES     = 236;
    localparam int OPT_START     = 240;
    localparam int YIADDR_FIRST  = 16;
    localparam int YIADDR_LAST   = 19;

    localparam logic [7:0] OPT_PAD    = 8'd0;
    localparam logic [7:0] OPT_MASK   = 8'd1;
    localparam logic [7:0] OPT_ROUTER = 8'd3;
    localparam logic [7:0] OPT_DNS    = 8'd6;
    localparam logic [7:0] OPT_LEASE  = 8'd51;
    localparam logic [7:0] OPT_TYPE   = 8'd53;
    localparam logic [7:0] OPT_SERVER = 8'd54;
    localparam logic [7:0] OPT_END    = 8'd255;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TOO_SHORT  = 2'd1;
    localparam logic [1:0] ST_BAD_COOKIE = 2'd2;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_CODE   = 5'b00010,
        PH_LEN    = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  msg_type;
        logic [31:0] client_addr;
        logic [31:0] subnet_mask;
        logic [5:0]  prefix_len;
        logic [31:0] gateway_addr;
        logic [31:0] dns_primary;
        logic [31:0] dns_secondary;
        logic [31:0] server_ident;
        logic [31:0] lease_secs;
    } t_result;

    // magic cookie 99.130.83.99
    function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'd99;
            2'd1:    b = 8'd130;
            2'd2:    b = 8'd83;
            default: b = 8'd99;
        endcase
        return b;
    endfunction

    // count of leading ones: 31 minus the highest zero bit, 32 when none
    function automatic logic [5:0] leading_ones(input logic [31:0] m);
        logic [5:0] cnt;
        cnt = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (!m[i]) begin
                cnt = 6'(31 - i);
            end
        end
        return cnt;
    endfunction

endpackage

// File: rtl/dhcp_in_if.sv
`timescale 1ns / 1ps

interface dhcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       msg_last;

    modport source (output valid, output data_byte, output msg_last, input ready);
    modport sink   (input valid, input data_byte, input msg_last, output ready);
endinterface

// File: rtl/dhcp_out_if.sv
`timescale 1ns / 1ps

interface dhcp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  msg_type;
    logic [31:0] client_addr;
    logic [31:0] subnet_mask;
    logic [5:0]  prefix_len;
    logic [31:0] gateway_addr;
    logic [31:0] dns_primary;
    logic [31:0] dns_secondary;
    logic [31:0] server_ident;
    logic [31:0] lease_secs;

    modport source (
        output valid, output status, output msg_type, output client_addr,
        output subnet_mask, output prefix_len, output gateway_addr,
        output dns_primary, output dns_secondary, output server_ident,
        output lease_secs, input ready
    );
    modport sink (
        input valid, input status, input msg_type, input client_addr,
        input subnet_mask, input prefix_len, input gateway_addr,
        input dns_primary, input dns_secondary, input server_ident,
        input lease_secs, output ready
    );
endinterface

// File: rtl/dhcp_opt_walk.sv
`timescale 1ns / 1ps

module dhcp_opt_walk (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output logic              o_res_valid,
    output dhcp_pkg::t_result o_res
);
    import dhcp_pkg::*;

    localparam logic [OFS_W-1:0] OFS_MAX = OFS_W'(MAX_MSG_BYTES);

    logic [OFS_W-1:0] r_offset, n_offset;
    t_phase           r_phase, n_phase;
    logic [7:0]       r_code, n_code;
    logic [7:0]       r_rem, n_rem;
    logic [3:0]       r_idx, n_idx;
    logic [63:0]      r_shift, n_shift;
    logic             r_cookie, n_cookie;
    logic [31:0]      r_client, n_client;
    logic [31:0]      r_mask, n_mask;
    logic [5:0]       r_prefix, n_prefix;
    logic [31:0]      r_gw, n_gw;
    logic [31:0]      r_dns1, n_dns1;
    logic [31:0]      r_dns2, n_dns2;
    logic [31:0]      r_server, n_server;
    logic [31:0]      r_lease, n_lease;
    logic [7:0]       r_type, n_type;

    logic             w_commit;
    logic [31:0]      w_first;
    logic [7:0]       w_type_byte;

    always_comb begin
        n_offset = r_offset;
        n_phase  = r_phase;
        n_code   = r_code;
        n_rem    = r_rem;
        n_idx    = r_idx;
        n_shift  = r_shift;
        n_cookie = r_cookie;
        n_client = r_client;
        n_mask   = r_mask;
        n_prefix = r_prefix;
        n_gw     = r_gw;
        n_dns1   = r_dns1;
        n_dns2   = r_dns2;
        n_server = r_server;
        n_lease  = r_lease;
        n_type   = r_type;
        w_commit = 1'b0;
        w_first  = '0;
        w_type_byte = '0;
        o_res    = '0;

        if (i_step && (r_offset < OFS_MAX)) begin
            n_offset = r_offset + 1'b1;
            case (r_phase)
                PH_HEADER: begin
                    if ((r_offset >= OFS_W'(YIADDR_FIRST)) &&
                        (r_offset <= OFS_W'(YIADDR_LAST))) begin
                        n_client = {r_client[23:0], i_byte};
                    end
                    if ((r_offset >= OFS_W'(HDR_BYTES)) &&
                        (r_offset < OFS_W'(OPT_START))) begin
                        // header length is a multiple of four
                        if (i_byte != cookie_byte(r_offset[1:0])) begin
                            n_cookie = 1'b0;
                        end
                        if (r_offset == OFS_W'(OPT_START - 1)) begin
                            n_phase = PH_CODE;
                        end
                    end
                end
                PH_CODE: begin
                    if (i_byte == OPT_END) begin
                        n_phase = PH_DONE;
                    end else if (i_byte != OPT_PAD) begin
                        n_code  = i_byte;
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    // zero length never updates anything
                    n_rem   = i_byte;
                    n_idx   = '0;
                    n_shift = '0;
                    n_phase = (i_byte == 8'd0) ? PH_CODE : PH_DATA;
                end
                PH_DATA: begin
                    if (r_idx < 4'd8) begin
                        n_shift = {r_shift[55:0], i_byte};
                        n_idx   = r_idx + 1'b1;
                    end
                    n_rem = r_rem - 1'b1;
                    if (n_rem == 8'd0) begin
                        w_commit = 1'b1;
                        n_phase  = PH_CODE;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase
        end

        // first four kept data bytes, and the first kept byte for message type
        case (n_idx)
            4'd4:    w_first = n_shift[31:0];
            4'd5:    w_first = n_shift[39:8];
            4'd6:    w_first = n_shift[47:16];
            4'd7:    w_first = n_shift[55:24];
            4'd8:    w_first = n_shift[63:32];
            default: w_first = '0;
        endcase
        case (n_idx)
            4'd1:    w_type_byte = n_shift[7:0];
            4'd2:    w_type_byte = n_shift[15:8];
            4'd3:    w_type_byte = n_shift[23:16];
            4'd4:    w_type_byte = n_shift[31:24];
            4'd5:    w_type_byte = n_shift[39:32];
            4'd6:    w_type_byte = n_shift[47:40];
            4'd7:    w_type_byte = n_shift[55:48];
            4'd8:    w_type_byte = n_shift[63:56];
            default: w_type_byte = '0;
        endcase

        if (w_commit) begin
            if (r_code == OPT_TYPE) begin
                if (n_idx != 4'd0) begin
                    n_type = w_type_byte;
                end
            end else if (n_idx >= 4'd4) begin
                case (r_code)
                    OPT_MASK: begin
                        n_mask   = w_first;
                        n_prefix = leading_ones(w_first);
                    end
                    OPT_ROUTER: n_gw = w_first;
                    OPT_DNS: begin
                        n_dns1 = w_first;
                        if (n_idx == 4'd8) begin
                            n_dns2 = n_shift[31:0];
                        end
                    end
                    OPT_LEASE:  n_lease  = w_first;
                    OPT_SERVER: n_server = w_first;
                    default: begin
                    end
                endcase
            end
        end

        if (n_offset < OFS_W'(OPT_START)) begin
            o_res.status = ST_TOO_SHORT;
        end else if (!n_cookie) begin
            o_res.status = ST_BAD_COOKIE;
        end else begin
            o_res.status        = ST_OK;
            o_res.msg_type      = n_type;
            o_res.client_addr   = n_client;
            o_res.subnet_mask   = n_mask;
            o_res.prefix_len    = n_prefix;
            o_res.gateway_addr  = n_gw;
            o_res.dns_primary   = n_dns1;
            o_res.dns_secondary = n_dns2;
            o_res.server_ident  = n_server;
            o_res.lease_secs    = n_lease;
        end
    end

    assign o_res_valid = i_step && i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_res_valid) begin
            r_offset <= '0;
            r_phase  <= PH_HEADER;
            r_code   <= '0;
            r_rem    <= '0;
            r_idx    <= '0;
            r_shift  <= '0;
            r_cookie <= 1'b1;
            r_client <= '0;
            r_mask   <= '0;
            r_prefix <= '0;
            r_gw     <= '0;
            r_dns1   <= '0;
            r_dns2   <= '0;
            r_server <= '0;
            r_lease  <= '0;
            r_type   <= '0;
        end else begin
            r_offset <= n_offset;
            r_phase  <= n_phase;
            r_code   <= n_code;
            r_rem    <= n_rem;
            r_idx    <= n_idx;
            r_shift  <= n_shift;
            r_cookie <= n_cookie;
            r_client <= n_client;
            r_mask   <= n_mask;
            r_prefix <= n_prefix;
            r_gw     <= n_gw;
            r_dns1   <= n_dns1;
            r_dns2   <= n_dns2;
            r_server <= n_server;
            r_lease  <= n_lease;
            r_type   <= n_type;
        end
    end

endmodule

// File: rtl/dhcp_reply_option_parser.sv
`timescale 1ns / 1ps

// DHCP reply parser. Takes a DHCP message one byte per beat on i_in, starting
// at the op byte, with msg_last set on the final byte. One result beat per
// message leaves on o_out: status (0 ok, 1 shorter than 240 bytes, 2 magic
// cookie mismatch), yiaddr, message type, subnet mask and its prefix length,
// first router, first two DNS servers, server identifier and lease time, all
// big-endian. On an error status every other field is zero. A later option
// overwrites an earlier one; options cut off by the end of the message, or
// lying past MAX_MSG_BYTES, are dropped; anything after the end option is
// ignored. Absent options read as zero.
// Rate: one byte per clock, back to back, message ends included, unless a
// final byte is held up as below. Bytes pass an input register, then the
// option walker updates its state; a final byte loads the result into an
// output register, which drives o_out.valid. A final byte waits in the
// input register only while the previous result is held and o_out.ready
// is low, so a stalled o_out holds up i_in only when a further message end
// arrives.

module dhcp_reply_option_parser (
    input  logic i_clk,
    input  logic i_rst_n,
    dhcp_in_if.sink    i_in,
    dhcp_out_if.source o_out
);
    import dhcp_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // output register
    logic       r_out_valid;
    t_result    r_out;

    logic       w_step;
    logic       w_res_valid;
    t_result    w_res;

    // a final byte needs the output register empty or leaving this cycle
    assign w_step     = r_in_valid && (!r_in_last || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.msg_last;
        end
    end

    dhcp_opt_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out.status;
    assign o_out.msg_type      = r_out.msg_type;
    assign o_out.client_addr   = r_out.client_addr;
    assign o_out.subnet_mask   = r_out.subnet_mask;
    assign o_out.prefix_len    = r_out.prefix_len;
    assign o_out.gateway_addr  = r_out.gateway_addr;
    assign o_out.dns_primary   = r_out.dns_primary;
    assign o_out.dns_secondary = r_out.dns_secondary;
    assign o_out.server_ident  = r_out.server_ident;
    assign o_out.lease_secs    = r_out.lease_secs;

endmodule
